>>> sv/bta_pkg.sv
// shared types and constants for the block table allocator
// no dependencies
package bta_pkg;

  localparam int unsigned NumBlocks = 256;
  localparam int unsigned IdxW      = $clog2(NumBlocks);
  localparam int unsigned CntW      = $clog2(NumBlocks + 1);
  localparam int unsigned BsW       = 13;
  localparam int unsigned SizeW     = 21;
  localparam int unsigned OffW      = 20;
  localparam int unsigned PctW      = 7;
  localparam int unsigned AddrW     = 3;

  localparam logic [AddrW-1:0] RegBlockSize   = 3'd0;
  localparam logic [AddrW-1:0] RegBlocksInUse = 3'd4;

  typedef enum logic [1:0] {
    ModeAlloc   = 2'd0,
    ModeFree    = 2'd1,
    ModeRealloc = 2'd2,
    ModeQuery   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StZero    = 2'd1,
    StNoSpace = 2'd2,
    StRange   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SClear,
    SNeedDiv,
    SAllocChk,
    SScan,
    SMark,
    SFreeDiv,
    SFreeRd,
    SFreeWait,
    SFreeClr,
    SQuery,
    SPctDiv,
    SDone
  } state_e;

endpackage

>>> sv/bta_ram.sv
// generic single port ram with registered read
// no dependencies
module bta_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> sv/block_table_allocator.sv
// block table allocator: one request at a time, taken only while idle
// result held in done while an earlier result waits
// allocate: divide + scan one entry per cycle + mark the run; realloc then also frees
// free: divide + read + clear one entry per cycle; query: scan + divide
// reset clears the table, no request taken meanwhile
// uses bta_pkg and bta_ram
module block_table_allocator
  import bta_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       mode_i,
  input  logic [SizeW-1:0] size_bytes_i,
  input  logic [OffW-1:0]  byte_offset_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [OffW-1:0]  result_offset_o,
  output logic [PctW-1:0]  usage_percent_o
);

  logic [BsW-1:0]  bs_q;
  logic [8:0]      biu_q;
  state_e          state_q, state_d;

  logic [1:0]       mode_q;
  logic [OffW-1:0]  off_q;

  // shared restoring divider
  logic [SizeW-1:0] dq_q, dq_d;
  logic [SizeW:0]   drem_q, drem_d;
  logic [4:0]       dcnt_q, dcnt_d;
  logic [SizeW:0]   dtrial;
  logic [BsW-1:0]   dvsr;

  logic [IdxW:0]    idx_q, idx_d;
  logic [CntW-1:0]  run_q, run_d;
  logic [CntW-1:0]  need_q, need_d;
  logic [CntW-1:0]  left_q, left_d;
  logic [CntW-1:0]  used_q, used_d;
  logic [IdxW:0]    base_q, base_d;
  logic [1:0]       st_q, st_d;
  logic [OffW-1:0]  roff_q, roff_d;
  logic [PctW-1:0]  pct_q, pct_d;
  logic             ov_q, ov_d;
  logic [1:0]       ost_q;
  logic [OffW-1:0]  ooff_q;
  logic [PctW-1:0]  opct_q;
  logic             rvalid_d;

  logic            we;
  logic [IdxW-1:0] addr;
  logic [CntW-1:0] wdata, rdata;

  logic [BsW-1:0]  bs_eff;
  logic [CntW-1:0] nb;
  logic [OffW+BsW:0] pool_bytes;
  logic [IdxW+BsW:0] off_prod;
  logic              accept;

  assign bs_eff = (bs_q == '0) ? BsW'(1) : bs_q;
  always_comb begin
    nb = CntW'(biu_q);
    if (biu_q == '0) nb = CntW'(1);
    if ({23'd0, biu_q} > 32'(NumBlocks)) nb = CntW'(NumBlocks);
  end
  assign pool_bytes = (OffW+BsW+1)'(nb) * (OffW+BsW+1)'(bs_eff);
  assign off_prod   = (IdxW+BsW+1)'(idx_q) * (IdxW+BsW+1)'(bs_eff);
  assign pready = 1'b1;
  assign prdata = (paddr == RegBlockSize)   ? 32'(bs_q) :
                  (paddr == RegBlocksInUse) ? 32'(biu_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q  <= BsW'(32);
      biu_q <= 9'd256;
    end else if (psel && penable && pwrite) begin
      if (paddr == RegBlockSize)   bs_q  <= pwdata[BsW-1:0];
      if (paddr == RegBlocksInUse) biu_q <= pwdata[8:0];
    end
  end

  bta_ram #(.Width(CntW), .Depth(NumBlocks)) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign in_ready_o = (state_q == SIdle);
  assign accept     = in_valid_i && in_ready_o;
  // query divides by the managed blocks, everything else by the block size
  assign dvsr       = (state_q == SPctDiv) ? BsW'(nb) : bs_eff;
  assign dtrial     = {drem_q[SizeW-1:0], dq_q[SizeW-1]} - (SizeW+1)'(dvsr);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (accept) begin
        unique case (mode_e'(mode_i))
          ModeFree:  state_d = SFreeDiv;
          ModeQuery: state_d = SQuery;
          default:   state_d = (size_bytes_i == '0) ? SDone : SNeedDiv;
        endcase
      end
      SClear:    if (idx_q == (IdxW+1)'(NumBlocks - 1)) state_d = SIdle;
      SNeedDiv:  if (dcnt_q == 5'd0) state_d = SAllocChk;
      SAllocChk: state_d = (need_q > nb) ? SDone : SScan;
      SScan: begin
        if (idx_q != (IdxW+1)'(nb) && rdata == '0 && run_q + 1'b1 == need_q)
          state_d = SMark;
        else if (idx_q == '0) state_d = SDone;
      end
      SMark: if (left_q == CntW'(1)) begin
        state_d = (mode_q == ModeRealloc) ? SFreeDiv : SDone;
      end
      SFreeDiv: if (dcnt_q == 5'd0) begin
        state_d = ((OffW+BsW+1)'(off_q) >= pool_bytes) ? SDone : SFreeRd;
      end
      SFreeRd:   state_d = SFreeWait;
      SFreeWait: state_d = (rdata == '0) ? SDone : SFreeClr;
      SFreeClr:  if (left_q == CntW'(1) || base_q + 1'b1 >= (IdxW+1)'(nb))
        state_d = SDone;
      SQuery: if (idx_q == (IdxW+1)'(nb)) state_d = SPctDiv;
      SPctDiv: if (dcnt_q == 5'd0) state_d = SDone;
      SDone: if (!ov_q) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    idx_d = idx_q; run_d = run_q; need_d = need_q; left_d = left_q;
    used_d = used_q; base_d = base_q; st_d = st_q; roff_d = roff_q;
    pct_d = pct_q; dq_d = dq_q; drem_d = drem_q; dcnt_d = dcnt_q;
    ov_d = ov_q; rvalid_d = 1'b0;
    we = 1'b0; addr = idx_q[IdxW-1:0]; wdata = '0;
    if (out_valid_o && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      SIdle: if (accept) begin
        st_d = (mode_i != ModeFree && mode_i != ModeQuery && size_bytes_i == '0)
               ? StZero : StOk;
        roff_d = '0; pct_d = '0; used_d = '0; run_d = '0;
        dq_d = (mode_i == ModeFree) ? SizeW'(byte_offset_i) : size_bytes_i;
        drem_d = '0; dcnt_d = 5'(SizeW - 1);
        idx_d = '0;
      end
      SClear: begin
        we = 1'b1;
        idx_d = idx_q + 1'b1;
      end
      SNeedDiv, SFreeDiv, SPctDiv: begin
        if (!dtrial[SizeW]) begin
          drem_d = dtrial;
          dq_d = {dq_q[SizeW-2:0], 1'b1};
        end else begin
          drem_d = {drem_q[SizeW-1:0], dq_q[SizeW-1]};
          dq_d = {dq_q[SizeW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == 5'd0) begin
          if (state_q == SNeedDiv) begin
            if (dq_d > SizeW'(NumBlocks) ||
                (dq_d == SizeW'(NumBlocks) && drem_d != '0))
              need_d = CntW'(NumBlocks) + 1'b1;
            else
              need_d = CntW'(dq_d) + CntW'(drem_d != '0);
            idx_d = (IdxW+1)'(nb);
            run_d = '0;
          end else if (state_q == SFreeDiv) begin
            base_d = dq_d[IdxW:0];
            if ((OffW+BsW+1)'(off_q) >= pool_bytes && mode_q == ModeFree)
              st_d = StRange;
          end else begin
            pct_d = PctW'(dq_d);
          end
        end
      end
      SAllocChk: begin
        if (need_q > nb) st_d = StNoSpace;
        addr = IdxW'(idx_q - 1'b1);
        idx_d = idx_q - 1'b1;
      end
      SScan: begin
        // rdata is entry idx_q, next read issued at idx_q-1
        addr = IdxW'(idx_q - 1'b1);
        if (rdata != '0) run_d = '0;
        else run_d = run_q + 1'b1;
        if (rdata == '0 && run_q + 1'b1 == need_q) begin
          roff_d = off_prod[OffW-1:0];
          base_d = idx_q;
          left_d = need_q;
        end else if (idx_q == '0) begin
          st_d = StNoSpace;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      SMark: begin
        we = 1'b1; addr = base_q[IdxW-1:0]; wdata = need_q;
        base_d = base_q + 1'b1;
        left_d = left_q - 1'b1;
        if (left_q == CntW'(1)) begin
          dq_d = SizeW'(off_q); drem_d = '0; dcnt_d = 5'(SizeW - 1);
        end
      end
      SFreeRd: addr = base_q[IdxW-1:0];
      SFreeWait: left_d = rdata;
      SFreeClr: begin
        we = 1'b1; addr = base_q[IdxW-1:0];
        base_d = base_q + 1'b1;
        left_d = left_q - 1'b1;
      end
      SQuery: begin
        addr = idx_q[IdxW-1:0];
        idx_d = idx_q + 1'b1;
        if (idx_q != '0 && rdata != '0) used_d = used_q + 1'b1;
        if (idx_q == (IdxW+1)'(nb)) begin
          dq_d = SizeW'(used_d) * SizeW'(100);
          drem_d = '0; dcnt_d = 5'(SizeW - 1);
        end
      end
      SDone: if (!ov_q) begin
        ov_d = 1'b1; rvalid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // query reads entry i while idx_q is i, its data arrives while idx_q is i+1
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i; off_q <= byte_offset_i;
    end
    if (rvalid_d) begin
      ost_q <= st_q; ooff_q <= roff_q; opct_q <= pct_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      idx_q <= '0; run_q <= '0; need_q <= '0; left_q <= '0; used_q <= '0;
      base_q <= '0; st_q <= '0; roff_q <= '0; pct_q <= '0;
      dq_q <= '0; drem_q <= '0; dcnt_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d; run_q <= run_d; need_q <= need_d; left_q <= left_d;
      used_q <= used_d; base_q <= base_d; st_q <= st_d; roff_q <= roff_d;
      pct_q <= pct_d; dq_q <= dq_d; drem_q <= drem_d; dcnt_q <= dcnt_d;
      ov_q <= ov_d;
    end
  end

  assign out_valid_o     = ov_q;
  assign status_o        = ost_q;
  assign result_offset_o = ooff_q;
  assign usage_percent_o = opct_q;

endmodule

>>> sv/bta_checker.sv
// port level checks for the block table allocator, bound to the top level
// uses bta_pkg
module bta_checker
  import bta_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [1:0]      status_o,
  input logic [OffW-1:0] result_offset_o,
  input logic [PctW-1:0] usage_percent_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped while stalled");

  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken during work");

  a_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> usage_percent_o <= PctW'(100))
    else $error("usage above 100");

  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StOk |-> result_offset_o == '0)
    else $error("offset on failed request");

endmodule

bind block_table_allocator bta_checker u_bta_checker (.*);
